>>> hw/rtl/stop_mode_state_machine_macros.svh
// Assertion helpers for the stop mode controller.
`ifndef STOP_MODE_STATE_MACHINE_MACROS_SVH
`define STOP_MODE_STATE_MACHINE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define SMSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stop mode check failed");

// Next-cycle implication, checked out of reset.
`define SMSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stop mode sequencing check failed");

`else

`define SMSM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SMSM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/smsm_pkg.sv
`timescale 1ns / 1ps

package smsm_pkg;

  // Ticks without movement before the vehicle counts as stopped
  localparam int unsigned HOLD_TICKS_DEF = 15;

  localparam int unsigned DIST_W  = 24;
  localparam int unsigned CDIST_W = 23;
  localparam int unsigned MOT_W   = 16;
  localparam int unsigned CMOT_W  = 15;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned CIDX_W  = 4;

  typedef enum logic [1:0] {
    MODE_DRIVE     = 2'd0,
    MODE_STOPPING  = 2'd1,
    MODE_STOPPED   = 2'd2,
    MODE_EMERGENCY = 2'd3
  } mode_t;

  // Register indexes of the configuration port
  localparam logic [CIDX_W-1:0] CFG_DRIVE_DIST     = 4'd0;
  localparam logic [CIDX_W-1:0] CFG_DRIVE_OFFSET   = 4'd1;
  localparam logic [CIDX_W-1:0] CFG_STOPPING_DIST  = 4'd2;
  localparam logic [CIDX_W-1:0] CFG_ENTRY_SPEED    = 4'd3;
  localparam logic [CIDX_W-1:0] CFG_ENTRY_ACCEL    = 4'd4;
  localparam logic [CIDX_W-1:0] CFG_OVERSHOOT_DIST = 4'd5;
  localparam logic [CIDX_W-1:0] CFG_SMOOTH_STOP    = 4'd6;
  localparam logic [CIDX_W-1:0] CFG_OVERSHOOT_CHK  = 4'd7;

  typedef struct packed {
    logic [CDIST_W-1:0] drive_dist_mm;
    logic [CDIST_W-1:0] drive_offset_mm;
    logic [CDIST_W-1:0] stopping_dist_mm;
    logic [CMOT_W-1:0]  entry_speed_mms;
    logic [CMOT_W-1:0]  entry_accel_mms2;
    logic [CDIST_W-1:0] overshoot_dist_mm;
    logic               smooth_stop_on;
    logic               overshoot_check_on;
  } cfg_t;

  // Outcome of one control tick
  typedef struct packed {
    mode_t            mode;
    logic [CNT_W-1:0] still_ticks;
    logic             feedback_reset;
    logic             smooth_stop_start;
  } step_res_t;

endpackage

>>> hw/rtl/stop_mode_state_machine.sv
`timescale 1ns / 1ps
// Stop mode controller: takes one control tick per request and returns one result per
// request (new mode, feedback reset pulse, smooth stop start pulse). A request is taken
// every clock cycle while in_ready is high; an accepted request is held in the input
// register and its result is loaded into the result register once that register is
// free or being drained. While a result waits on out_ready the input register holds
// its request, and in_ready drops once both registers are full. The mode and still-count
// registers close their update loop on each evaluated request, so they keep up with
// that rate. Configuration writes are taken at once and must only be made while no
// request is in flight.

`include "stop_mode_state_machine_macros.svh"

module stop_mode_state_machine #(
  parameter int unsigned HOLD_TICKS = smsm_pkg::HOLD_TICKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [smsm_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [smsm_pkg::CDIST_W-1:0]        cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [smsm_pkg::DIST_W-1:0]  in_stop_dist,
  input  logic signed [smsm_pkg::MOT_W-1:0]   in_speed,
  input  logic signed [smsm_pkg::MOT_W-1:0]   in_accel,
  input  logic                                in_far_from_path,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_mode,
  output logic                                out_feedback_reset,
  output logic                                out_smooth_stop_start
);

  smsm_pkg::cfg_t      cfg;
  smsm_pkg::step_res_t res;

  logic                               in_valid_r;
  logic signed [smsm_pkg::DIST_W-1:0] stop_dist_r;
  logic signed [smsm_pkg::MOT_W-1:0]  speed_r;
  logic signed [smsm_pkg::MOT_W-1:0]  accel_r;
  logic                               far_r;

  smsm_pkg::mode_t             mode_r;
  logic [smsm_pkg::CNT_W-1:0]  still_r;

  logic            out_valid_r;
  smsm_pkg::mode_t out_mode_r;
  logic            out_fb_r;
  logic            out_ss_r;

  logic fire;

  smsm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  smsm_step #(
    .HOLD_TICKS (HOLD_TICKS)
  ) u_step (
    .cfg           (cfg),
    .cur_mode      (mode_r),
    .cur_still     (still_r),
    .line_dist     (stop_dist_r),
    .speed         (speed_r),
    .accel         (accel_r),
    .far_from_path (far_r),
    .res           (res)
  );

  // Advance when the result register is free or being drained
  assign fire     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stop_dist_r <= in_stop_dist;
      speed_r     <= in_speed;
      accel_r     <= in_accel;
      far_r       <= in_far_from_path;
    end
  end

  // Mode and still count advance with each evaluated request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= smsm_pkg::MODE_STOPPED;
      still_r <= '0;
    end else if (fire) begin
      mode_r  <= res.mode;
      still_r <= res.still_ticks;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_mode_r <= res.mode;
      out_fb_r   <= res.feedback_reset;
      out_ss_r   <= res.smooth_stop_start;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_mode              = out_mode_r;
  assign out_feedback_reset    = out_fb_r;
  assign out_smooth_stop_start = out_ss_r;

  // Checks
  `SMSM_ASSERT_IMPL(a_fb_to_drive, clk, rst_n, out_valid_r && out_fb_r, out_mode_r == smsm_pkg::MODE_DRIVE)
  `SMSM_ASSERT_IMPL(a_ss_to_stopping, clk, rst_n, out_valid_r && out_ss_r, out_mode_r == smsm_pkg::MODE_STOPPING)
  `SMSM_ASSERT_IMPL(a_pulses_exclusive, clk, rst_n, out_valid_r, !(out_fb_r && out_ss_r))
  `SMSM_ASSERT_NEXT(a_fire_shows_result, clk, rst_n, fire, out_valid_r && (out_mode_r == mode_r))
  `SMSM_ASSERT_NEXT(a_far_emergency, clk, rst_n, fire && far_r, mode_r == smsm_pkg::MODE_EMERGENCY)

endmodule

>>> hw/rtl/smsm_cfg.sv
`timescale 1ns / 1ps

module smsm_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [smsm_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [smsm_pkg::CDIST_W-1:0]      cfg_wdata,
  output smsm_pkg::cfg_t                    cfg
);

  smsm_pkg::cfg_t cfg_r;

  // Writes are always accepted
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Hold registers, update the addressed one; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drive_dist_mm      <= smsm_pkg::CDIST_W'(500);
      cfg_r.drive_offset_mm    <= smsm_pkg::CDIST_W'(1000);
      cfg_r.stopping_dist_mm   <= smsm_pkg::CDIST_W'(3000);
      cfg_r.entry_speed_mms    <= smsm_pkg::CMOT_W'(200);
      cfg_r.entry_accel_mms2   <= smsm_pkg::CMOT_W'(200);
      cfg_r.overshoot_dist_mm  <= smsm_pkg::CDIST_W'(1500);
      cfg_r.smooth_stop_on     <= 1'b1;
      cfg_r.overshoot_check_on <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        smsm_pkg::CFG_DRIVE_DIST:     cfg_r.drive_dist_mm      <= cfg_wdata;
        smsm_pkg::CFG_DRIVE_OFFSET:   cfg_r.drive_offset_mm    <= cfg_wdata;
        smsm_pkg::CFG_STOPPING_DIST:  cfg_r.stopping_dist_mm   <= cfg_wdata;
        smsm_pkg::CFG_ENTRY_SPEED:    cfg_r.entry_speed_mms    <= cfg_wdata[smsm_pkg::CMOT_W-1:0];
        smsm_pkg::CFG_ENTRY_ACCEL:    cfg_r.entry_accel_mms2   <= cfg_wdata[smsm_pkg::CMOT_W-1:0];
        smsm_pkg::CFG_OVERSHOOT_DIST: cfg_r.overshoot_dist_mm  <= cfg_wdata;
        smsm_pkg::CFG_SMOOTH_STOP:    cfg_r.smooth_stop_on     <= cfg_wdata[0];
        smsm_pkg::CFG_OVERSHOOT_CHK:  cfg_r.overshoot_check_on <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/smsm_step.sv
`timescale 1ns / 1ps

module smsm_step #(
  parameter int unsigned HOLD_TICKS = smsm_pkg::HOLD_TICKS_DEF
) (
  input  smsm_pkg::cfg_t                      cfg,
  input  smsm_pkg::mode_t                     cur_mode,
  input  logic [smsm_pkg::CNT_W-1:0]          cur_still,
  input  logic signed [smsm_pkg::DIST_W-1:0]  line_dist,
  input  logic signed [smsm_pkg::MOT_W-1:0]   speed,
  input  logic signed [smsm_pkg::MOT_W-1:0]   accel,
  input  logic                                far_from_path,
  output smsm_pkg::step_res_t                 res
);

  localparam int unsigned CW = smsm_pkg::DIST_W + 1;

  logic [smsm_pkg::MOT_W:0]   speed_mag;
  logic [smsm_pkg::MOT_W:0]   accel_mag;
  logic                       moving;
  logic [smsm_pkg::CNT_W-1:0] still_inc;
  logic [smsm_pkg::CNT_W-1:0] still_nxt;
  logic                       stopped;
  logic [smsm_pkg::DIST_W-1:0] depart_sum;
  logic signed [CW-1:0]       dist_x;
  logic                       depart_stopping;
  logic                       depart_stopped;
  logic                       near_line;
  logic                       emerg;

  // Magnitudes of speed and acceleration, one bit wider to hold -min
  assign speed_mag = speed[smsm_pkg::MOT_W-1] ? (~{speed[smsm_pkg::MOT_W-1], speed} + 1'b1)
                                              : {1'b0, speed};
  assign accel_mag = accel[smsm_pkg::MOT_W-1] ? (~{accel[smsm_pkg::MOT_W-1], accel} + 1'b1)
                                              : {1'b0, accel};
  assign moving = (speed_mag > {2'b00, cfg.entry_speed_mms}) ||
                  (accel_mag > {2'b00, cfg.entry_accel_mms2});

  // Saturating still count; far ticks count as still
  assign still_inc = (&cur_still) ? cur_still : cur_still + 1'b1;
  assign still_nxt = (moving && !far_from_path) ? '0 : still_inc;
  assign stopped   = still_nxt >= smsm_pkg::CNT_W'(HOLD_TICKS);

  // Distance compares in one common signed width
  assign dist_x          = CW'(line_dist);
  assign depart_sum      = {1'b0, cfg.drive_dist_mm} + {1'b0, cfg.drive_offset_mm};
  assign depart_stopping = dist_x > $signed({1'b0, depart_sum});
  assign depart_stopped  = dist_x > $signed({2'b00, cfg.drive_dist_mm});
  assign near_line       = dist_x < $signed({2'b00, cfg.stopping_dist_mm});
  assign emerg           = cfg.overshoot_check_on &&
                           (dist_x < -$signed({2'b00, cfg.overshoot_dist_mm}));

  // Mode transition
  always_comb begin
    res.mode              = cur_mode;
    res.still_ticks       = still_nxt;
    res.feedback_reset    = 1'b0;
    res.smooth_stop_start = 1'b0;
    if (far_from_path) begin
      res.mode = smsm_pkg::MODE_EMERGENCY;
    end else begin
      case (cur_mode)
        smsm_pkg::MODE_DRIVE: begin
          if (emerg) begin
            res.mode = smsm_pkg::MODE_EMERGENCY;
          end else if (cfg.smooth_stop_on) begin
            if (near_line) begin
              res.mode              = smsm_pkg::MODE_STOPPING;
              res.smooth_stop_start = 1'b1;
            end
          end else if (stopped && !depart_stopped) begin
            res.mode = smsm_pkg::MODE_STOPPED;
          end
        end
        smsm_pkg::MODE_STOPPING: begin
          if (emerg) begin
            res.mode = smsm_pkg::MODE_EMERGENCY;
          end else if (stopped) begin
            res.mode = smsm_pkg::MODE_STOPPED;
          end else if (depart_stopping) begin
            res.mode           = smsm_pkg::MODE_DRIVE;
            res.feedback_reset = 1'b1;
          end
        end
        smsm_pkg::MODE_STOPPED: begin
          if (depart_stopped) begin
            res.mode           = smsm_pkg::MODE_DRIVE;
            res.feedback_reset = 1'b1;
          end
        end
        default: begin
          if (stopped && !emerg) begin
            res.mode = smsm_pkg::MODE_STOPPED;
          end
        end
      endcase
    end
  end

endmodule
